// ===== rtl/pfsr_pkg.sv =====
// pfsr_pkg: types and constants for the status field reader core
// no dependencies

package pfsr_pkg;

  // parse position inside one frame
  typedef enum logic [2:0] {
    PH_ID0     = 3'd0,
    PH_ID1     = 3'd1,
    PH_TAG     = 3'd2,
    PH_VALUE   = 3'd3,
    PH_SKIPVAR = 3'd4,
    PH_LENVAR  = 3'd5,
    PH_SKIPRUN = 3'd6,
    PH_IDLE    = 3'd7
  } phase_e;

  // frame outcome so far
  typedef enum logic [1:0] {
    DONE_NONE  = 2'd0,
    DONE_FOUND = 2'd1,
    DONE_BAD   = 2'd2
  } done_e;

  // protobuf wire types
  localparam logic [2:0] WIRE_VARINT = 3'd0;
  localparam logic [2:0] WIRE_FIX64  = 3'd1;
  localparam logic [2:0] WIRE_LEN    = 3'd2;
  localparam logic [2:0] WIRE_FIX32  = 3'd5;

  localparam int unsigned ACC_W    = 35;
  localparam int unsigned STATUS_W = 32;
  localparam int unsigned CNT_W    = 4;

  // last legal varint byte index (ten bytes in all)
  localparam logic [CNT_W-1:0] VARINT_LAST_IDX = 4'd9;

  // tag value of field 1, wire type varint
  localparam logic [ACC_W-1:0] STATUS_TAG = 35'd8;

  localparam logic [STATUS_W-1:0] FIX64_LEN = 32'd8;
  localparam logic [STATUS_W-1:0] FIX32_LEN = 32'd4;

endpackage

// ===== rtl/protobuf_status_field_reader_core.sv =====
// protobuf_status_field_reader_core: pulls the field 1 varint out of a framed protobuf message
// depends on pfsr_pkg; checked by pfsr_checker (bound in its own file)
//
// channel   dir  payload                                   handshake
// s_axis    in   tdata[7:0] data_byte, tlast last_byte      tvalid/tready
// m_axis    out  tdata[31:0] status_value, tuser[0] found   tvalid/tready
//
// one byte per cycle sustained while no stalled result holds back a last byte; the parse state
// is loaded from the input register when its byte is consumed, the result register when a last
// byte is, so m_axis_tvalid rises once the last byte has passed the input register and the result register
// reset: parser waits for the first message id byte, no result pending
// a stalled result only holds back a last byte; other bytes keep flowing

module protobuf_status_field_reader_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] status_value (signed)
  output logic        m_axis_tuser    // [0] found
);

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // parse state
  pfsr_pkg::phase_e                phase_q, phase_d;
  logic [pfsr_pkg::ACC_W-1:0]      acc_q, acc_d;
  logic [pfsr_pkg::CNT_W-1:0]      vcnt_q, vcnt_d;
  logic [pfsr_pkg::STATUS_W-1:0]   skip_q, skip_d;
  logic [pfsr_pkg::STATUS_W-1:0]   capt_q, capt_d;
  pfsr_pkg::done_e                 done_q, done_d;
  logic                            lover_q, lover_d;

  // result register
  logic                            out_valid_q;
  logic                            found_q, found_d;
  logic [pfsr_pkg::STATUS_W-1:0]   status_q, status_d;

  logic out_free;
  logic consume;
  logic in_take;

  // varint byte decode
  logic [6:0]                  payload;
  logic [pfsr_pkg::ACC_W-1:0]  shifted;
  logic [pfsr_pkg::ACC_W-1:0]  acc_new;
  logic                        over_bit;
  logic                        lover_new;
  logic                        vend;
  logic                        vbad;

  // handshake
  assign out_free      = !out_valid_q || m_axis_tready;
  assign consume       = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready = !in_valid_q || consume;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // place the seven payload bits and track bits from 2^32 up to 2^63
  always_comb begin
    payload = in_byte_q[6:0];
    case (vcnt_q)
      4'd0:    shifted = {28'b0, payload};
      4'd1:    shifted = {21'b0, payload, 7'b0};
      4'd2:    shifted = {14'b0, payload, 14'b0};
      4'd3:    shifted = {7'b0, payload, 21'b0};
      4'd4:    shifted = {payload, 28'b0};
      default: shifted = '0;
    endcase
    case (vcnt_q) inside
      4'd4:          over_bit = |payload[6:4];
      [4'd5:4'd8]:   over_bit = |payload;
      4'd9:          over_bit = payload[0];
      default:       over_bit = 1'b0;
    endcase
    acc_new   = acc_q | shifted;
    lover_new = lover_q | over_bit;
    vend      = !in_byte_q[7];
    vbad      = in_byte_q[7] && (vcnt_q >= pfsr_pkg::VARINT_LAST_IDX);
  end

  // next parse state
  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    vcnt_d  = vcnt_q;
    skip_d  = skip_q;
    capt_d  = capt_q;
    done_d  = done_q;
    lover_d = lover_q;
    case (phase_q)
      pfsr_pkg::PH_ID0: begin
        phase_d = pfsr_pkg::PH_ID1;
      end
      pfsr_pkg::PH_ID1: begin
        phase_d = pfsr_pkg::PH_TAG;
        acc_d   = '0;
        vcnt_d  = '0;
        lover_d = 1'b0;
      end
      pfsr_pkg::PH_TAG, pfsr_pkg::PH_VALUE, pfsr_pkg::PH_SKIPVAR,
      pfsr_pkg::PH_LENVAR: begin
        acc_d   = acc_new;
        lover_d = lover_new;
        if (vbad) begin
          done_d  = pfsr_pkg::DONE_BAD;
          phase_d = pfsr_pkg::PH_IDLE;
        end else if (!vend) begin
          vcnt_d = vcnt_q + 4'd1;
        end else begin
          // varint complete: start a fresh one by default
          acc_d   = '0;
          vcnt_d  = '0;
          lover_d = 1'b0;
          case (phase_q)
            pfsr_pkg::PH_TAG: begin
              if (acc_new == pfsr_pkg::STATUS_TAG) begin
                phase_d = pfsr_pkg::PH_VALUE;
              end else begin
                case (acc_new[2:0])
                  pfsr_pkg::WIRE_VARINT: phase_d = pfsr_pkg::PH_SKIPVAR;
                  pfsr_pkg::WIRE_FIX64: begin
                    skip_d  = pfsr_pkg::FIX64_LEN;
                    phase_d = pfsr_pkg::PH_SKIPRUN;
                  end
                  pfsr_pkg::WIRE_LEN:    phase_d = pfsr_pkg::PH_LENVAR;
                  pfsr_pkg::WIRE_FIX32: begin
                    skip_d  = pfsr_pkg::FIX32_LEN;
                    phase_d = pfsr_pkg::PH_SKIPRUN;
                  end
                  default: begin
                    done_d  = pfsr_pkg::DONE_BAD;
                    phase_d = pfsr_pkg::PH_IDLE;
                  end
                endcase
              end
            end
            pfsr_pkg::PH_VALUE: begin
              capt_d  = acc_new[pfsr_pkg::STATUS_W-1:0];
              done_d  = pfsr_pkg::DONE_FOUND;
              phase_d = pfsr_pkg::PH_IDLE;
            end
            pfsr_pkg::PH_SKIPVAR: begin
              phase_d = pfsr_pkg::PH_TAG;
            end
            default: begin
              // length of a delimited run
              if (lover_new) begin
                done_d  = pfsr_pkg::DONE_BAD;
                phase_d = pfsr_pkg::PH_IDLE;
              end else begin
                skip_d  = acc_new[pfsr_pkg::STATUS_W-1:0];
                phase_d = (acc_new[pfsr_pkg::STATUS_W-1:0] == '0) ?
                          pfsr_pkg::PH_TAG : pfsr_pkg::PH_SKIPRUN;
              end
            end
          endcase
        end
      end
      pfsr_pkg::PH_SKIPRUN: begin
        if (skip_q <= 32'd1) begin
          skip_d  = '0;
          phase_d = pfsr_pkg::PH_TAG;
          acc_d   = '0;
          vcnt_d  = '0;
          lover_d = 1'b0;
        end else begin
          skip_d = skip_q - 32'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // frame result
  always_comb begin
    found_d  = (done_d == pfsr_pkg::DONE_FOUND);
    status_d = found_d ? capt_d : '1;
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // parse state, rearmed after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pfsr_pkg::PH_ID0;
      acc_q   <= '0;
      vcnt_q  <= '0;
      skip_q  <= '0;
      capt_q  <= '1;
      done_q  <= pfsr_pkg::DONE_NONE;
      lover_q <= 1'b0;
    end else if (consume) begin
      if (in_last_q) begin
        phase_q <= pfsr_pkg::PH_ID0;
        acc_q   <= '0;
        vcnt_q  <= '0;
        skip_q  <= '0;
        capt_q  <= '1;
        done_q  <= pfsr_pkg::DONE_NONE;
        lover_q <= 1'b0;
      end else begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        vcnt_q  <= vcnt_d;
        skip_q  <= skip_d;
        capt_q  <= capt_d;
        done_q  <= done_d;
        lover_q <= lover_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (consume && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && in_last_q) begin
      found_q  <= found_d;
      status_q <= status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = status_q;
  assign m_axis_tuser  = found_q;

endmodule

// ===== rtl/pfsr_checker.sv =====
// pfsr_checker: port-level assertions for the status field reader core
// depends on protobuf_status_field_reader_core (attached by bind below)

module pfsr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // a frame without the status field reports all ones
  a_not_found_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 32'hFFFF_FFFF)
    else $error("not-found result carries a value");

  // with no result pending the input side never stalls
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

endmodule

bind protobuf_status_field_reader_core pfsr_checker u_pfsr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
